>>> hw/rtl/smb_pkg.sv
`timescale 1ns / 1ps

package smb_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int ID_W   = 8;
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   sender;
    logic [ID_W-1:0]   receiver;
    logic [WORD_W-1:0] payload;
  } smb_entry_t;

  typedef struct packed {
    logic              accepted;
    logic              found;
    logic [ID_W-1:0]   sender;
    logic [WORD_W-1:0] payload;
    logic [OCC_W-1:0]  occupancy;
  } smb_result_t;

endpackage

>>> hw/rtl/smb_store.sv
`timescale 1ns / 1ps

module smb_store #(
  parameter int Depth = smb_pkg::DEFAULT_DEPTH,
  localparam int AW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output smb_pkg::smb_entry_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  smb_pkg::smb_entry_t wr_data_i
);

  smb_pkg::smb_entry_t mem [Depth];
  smb_pkg::smb_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/smb_ctrl.sv
`timescale 1ns / 1ps

module smb_ctrl #(
  parameter int Depth = smb_pkg::DEFAULT_DEPTH,
  localparam int AW = $clog2(Depth),
  localparam int CW = $clog2(Depth + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [smb_pkg::ID_W-1:0]     src_id_i,
  input  logic [smb_pkg::ID_W-1:0]     dst_id_i,
  input  logic [smb_pkg::WORD_W-1:0]   payload_i,
  output logic                         res_valid_o,
  input  logic                         res_take_i,
  output smb_pkg::smb_result_t         res_o,
  output logic                         rd_en_o,
  output logic [AW-1:0]                rd_addr_o,
  input  smb_pkg::smb_entry_t          rd_data_i,
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_addr_o,
  output smb_pkg::smb_entry_t          wr_data_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic                         pend_q, pend_d;
  logic [AW-1:0]                data_idx_q, data_idx_d;
  logic [smb_pkg::ID_W-1:0]     rcv_q, rcv_d;
  logic                         accepted_q, accepted_d;
  logic                         found_q, found_d;
  logic [smb_pkg::ID_W-1:0]     sender_q, sender_d;
  logic [smb_pkg::WORD_W-1:0]   payload_q, payload_d;

  logic in_fire;
  logic issue;
  logic hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign issue      = (ptr_q < count_q);
  assign hit        = pend_q && (rd_data_i.receiver == rcv_q);

  assign rd_addr_o = ptr_q[AW-1:0];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    pend_d     = pend_q;
    data_idx_d = data_idx_q;
    rcv_d      = rcv_q;
    accepted_d = accepted_q;
    found_d    = found_q;
    sender_d   = sender_q;
    payload_d  = payload_q;
    rd_en_o    = 1'b0;
    wr_en_o    = 1'b0;
    wr_addr_o  = count_q[AW-1:0];
    wr_data_o  = '{sender: src_id_i, receiver: dst_id_i, payload: payload_i};

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          accepted_d = 1'b0;
          found_d    = 1'b0;
          sender_d   = '0;
          payload_d  = '0;
          rcv_d      = dst_id_i;
          ptr_d      = '0;
          pend_d     = 1'b0;
          if (op_i == smb_pkg::OP_SEND) begin
            if (count_q < CW'(Depth)) begin
              wr_en_o    = 1'b1;
              accepted_d = 1'b1;
              count_d    = count_q + CW'(1);
            end
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en_o = issue;
        pend_d  = issue;
        if (issue) begin
          ptr_d      = ptr_q + CW'(1);
          data_idx_d = ptr_q[AW-1:0];
        end
        if (hit) begin
          found_d   = 1'b1;
          sender_d  = rd_data_i.sender;
          payload_d = rd_data_i.payload;
          state_d   = ST_SHIFT;
        end else if (!pend_q && !issue) begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT: begin
        rd_en_o = issue;
        pend_d  = issue;
        if (issue) begin
          ptr_d      = ptr_q + CW'(1);
          data_idx_d = ptr_q[AW-1:0];
        end
        if (pend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = data_idx_q - AW'(1);
          wr_data_o = rd_data_i;
        end else if (!issue) begin
          count_d = count_q - CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_idx_q <= data_idx_d;
    rcv_q      <= rcv_d;
    accepted_q <= accepted_d;
    found_q    <= found_d;
    sender_q   <= sender_d;
    payload_q  <= payload_d;
  end

  assign res_valid_o     = (state_q == ST_DONE);
  assign res_o.accepted  = accepted_q;
  assign res_o.found     = found_q;
  assign res_o.sender    = sender_q;
  assign res_o.payload   = payload_q;
  assign res_o.occupancy = smb_pkg::OCC_W'(count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("held count exceeds depth");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (CW'(wr_addr_o) < count_q) || (state_q == ST_IDLE))
    else $error("compaction write outside the held messages");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_SCAN) || (state_q == ST_SHIFT))
    else $error("read data pending outside a receive");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.found && res_o.accepted))
    else $error("result both stored and found");

  a_shift_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) && (state_d == ST_DONE) |=> count_q == $past(count_q) - CW'(1))
    else $error("receive did not remove one message");
`endif

endmodule

>>> hw/rtl/selective_receive_mailbox.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  op_i, src_id_i, dst_id_i, payload_i
// out      output     out_valid_o/out_stall_i accepted_o, found_o, msg_sender_o,
//                                             msg_payload_o, occupancy_o
//
// A send transaction stores the message if there is room, then posts the result.
// In a receive transaction the scan and the compaction read one slot a cycle through the
// single read port of the store.
// The input stalls from acceptance until the result is handed to the output register.
// A new transaction is accepted while a finished result still waits on a stalled output.
// Reset empties the mailbox at once; the message store itself is not cleared.

module selective_receive_mailbox #(
  parameter int Depth = smb_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic [smb_pkg::ID_W-1:0]   src_id_i,
  input  logic [smb_pkg::ID_W-1:0]   dst_id_i,
  input  logic [smb_pkg::WORD_W-1:0] payload_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic                       found_o,
  output logic [smb_pkg::ID_W-1:0]   msg_sender_o,
  output logic [smb_pkg::WORD_W-1:0] msg_payload_o,
  output logic [smb_pkg::OCC_W-1:0]  occupancy_o
);

  localparam int AW = $clog2(Depth);

  logic                 res_valid;
  logic                 res_take;
  smb_pkg::smb_result_t res;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  smb_pkg::smb_entry_t  rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  smb_pkg::smb_entry_t  wr_data;

  logic                 out_valid_q, out_valid_d;
  smb_pkg::smb_result_t out_q, out_d;

  smb_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .src_id_i     (src_id_i),
    .dst_id_i     (dst_id_i),
    .payload_i    (payload_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  smb_store #(
    .Depth(Depth)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_q.accepted;
  assign found_o       = out_q.found;
  assign msg_sender_o  = out_q.sender;
  assign msg_payload_o = out_q.payload;
  assign occupancy_o   = out_q.occupancy;

endmodule

>>> bench/selective_receive_mailbox_tb.sv
`timescale 1ns / 1ps

module selective_receive_mailbox_tb;

  localparam int MBOX_DEPTH  = smb_pkg::DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       op = smb_pkg::OP_SEND;
  logic [smb_pkg::ID_W-1:0]   src_id = '0;
  logic [smb_pkg::ID_W-1:0]   dst_id = '0;
  logic [smb_pkg::WORD_W-1:0] payload = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       accepted;
  logic                       found;
  logic [smb_pkg::ID_W-1:0]   msg_sender;
  logic [smb_pkg::WORD_W-1:0] msg_payload;
  logic [smb_pkg::OCC_W-1:0]  occupancy;

  smb_pkg::smb_entry_t  held_msgs[$];
  smb_pkg::smb_result_t pending_results[$];

  bit in_idle_on  = 1'b0;
  bit out_idle_on = 1'b0;
  int errors      = 0;
  int cycles      = 0;
  int results_seen = 0;
  int n_items     = 0;
  int n_stored    = 0;
  int n_refused   = 0;
  int n_found     = 0;
  int n_missed    = 0;
  int peak_held   = 0;

  selective_receive_mailbox #(
    .Depth(MBOX_DEPTH)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .src_id_i     (src_id),
    .dst_id_i     (dst_id),
    .payload_i    (payload),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .accepted_o   (accepted),
    .found_o      (found),
    .msg_sender_o (msg_sender),
    .msg_payload_o(msg_payload),
    .occupancy_o  (occupancy)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Applies one transaction to the mailbox image and returns the result it must produce.
  function automatic smb_pkg::smb_result_t predict_mailbox(
      logic op_v, logic [smb_pkg::ID_W-1:0] snd, logic [smb_pkg::ID_W-1:0] rcv,
      logic [smb_pkg::WORD_W-1:0] word);
    smb_pkg::smb_result_t res;
    smb_pkg::smb_entry_t  msg;
    int                   hit;
    res = '0;
    hit = -1;
    if (op_v == smb_pkg::OP_SEND) begin
      if (held_msgs.size() < MBOX_DEPTH) begin
        msg.sender   = snd;
        msg.receiver = rcv;
        msg.payload  = word;
        held_msgs.push_back(msg);
        res.accepted = 1'b1;
      end
    end else begin
      for (int i = 0; i < held_msgs.size(); i++) begin
        if (hit < 0 && held_msgs[i].receiver == rcv) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        res.found   = 1'b1;
        res.sender  = held_msgs[hit].sender;
        res.payload = held_msgs[hit].payload;
        held_msgs.delete(hit);
      end
    end
    res.occupancy = smb_pkg::OCC_W'(held_msgs.size());
    return res;
  endfunction

  task automatic send_item(input logic op_v, input logic [smb_pkg::ID_W-1:0] snd,
                           input logic [smb_pkg::ID_W-1:0] rcv,
                           input logic [smb_pkg::WORD_W-1:0] word);
    smb_pkg::smb_result_t res;
    int                   gap;
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    op       = op_v;
    src_id   = snd;
    dst_id   = rcv;
    payload  = word;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    res = predict_mailbox(op_v, snd, rcv, word);
    pending_results.push_back(res);
    n_items++;
    if (op_v == smb_pkg::OP_SEND) begin
      if (res.accepted) n_stored++;
      else n_refused++;
    end else begin
      if (res.found) n_found++;
      else n_missed++;
    end
    if (held_msgs.size() > peak_held) peak_held = held_msgs.size();
  endtask

  task automatic note_error(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("Mismatch in result %0d on %s: expected %0h, got %0h.", results_seen, what, want,
               got);
    end
  endtask

  task automatic check_result();
    smb_pkg::smb_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      note_error("a result with no transaction pending", '0, '0);
      return;
    end
    want = pending_results.pop_front();
    if (accepted !== want.accepted)
      note_error("accepted", 32'(want.accepted), 32'(accepted));
    if (found !== want.found)
      note_error("found", 32'(want.found), 32'(found));
    if (msg_sender !== want.sender)
      note_error("msg_sender", 32'(want.sender), 32'(msg_sender));
    if (msg_payload !== want.payload)
      note_error("msg_payload", want.payload, msg_payload);
    if (occupancy !== want.occupancy)
      note_error("occupancy", 32'(want.occupancy), 32'(occupancy));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  initial begin : out_stall_gen
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (out_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(1, 10) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic test_empty_receive();
    send_item(smb_pkg::OP_RECV, 8'h00, 8'h00, 32'h0);
    send_item(smb_pkg::OP_RECV, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // Two messages share a receiver, so the older one must come out first.
  task automatic test_oldest_match();
    send_item(smb_pkg::OP_SEND, 8'h00, 8'h5A, 32'h0000_0000);
    send_item(smb_pkg::OP_SEND, 8'hFF, 8'h5A, 32'hFFFF_FFFF);
    send_item(smb_pkg::OP_SEND, 8'h11, 8'hA5, 32'h1234_5678);
    send_item(smb_pkg::OP_RECV, 8'h00, 8'h33, 32'h0);
    send_item(smb_pkg::OP_RECV, 8'h00, 8'h5A, 32'h0);
    send_item(smb_pkg::OP_RECV, 8'h00, 8'h5A, 32'h0);
    send_item(smb_pkg::OP_RECV, 8'h00, 8'hA5, 32'h0);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < MBOX_DEPTH; i++) begin
      send_item(smb_pkg::OP_SEND, 8'(255 - i), 8'(i), {4{8'(i * 17)}});
    end
    send_item(smb_pkg::OP_SEND, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(smb_pkg::OP_RECV, 8'h00, 8'(MBOX_DEPTH / 2), 32'h0);
    send_item(smb_pkg::OP_RECV, 8'h00, 8'(MBOX_DEPTH - 1), 32'h0);
    send_item(smb_pkg::OP_RECV, 8'h00, 8'h00, 32'h0);
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    int                       send_pct;
    logic                     op_v;
    logic [smb_pkg::ID_W-1:0] rcv;
    int                       roll;
    send_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 120 == 0) begin
        in_idle_on  = with_idle && ($urandom_range(0, 3) != 0);
        out_idle_on = with_idle && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: send_pct = 75;
          1: send_pct = 30;
          default: send_pct = 50;
        endcase
      end
      op_v = ($urandom_range(0, 99) < send_pct) ? smb_pkg::OP_SEND : smb_pkg::OP_RECV;
      roll = $urandom_range(0, 9);
      if (roll < 7) rcv = 8'($urandom_range(0, 5));
      else rcv = 8'($urandom);
      if (op_v == smb_pkg::OP_RECV && held_msgs.size() != 0 && $urandom_range(0, 9) < 6) begin
        rcv = held_msgs[$urandom_range(0, held_msgs.size() - 1)].receiver;
      end
      send_item(op_v, 8'($urandom), rcv, $urandom);
    end
  endtask

  task automatic test_back_to_back(input int count);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    test_random_traffic(count, 1'b0);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_empty_receive();
    test_oldest_match();
    test_full_store();
    test_random_traffic(1000, 1'b1);
    test_back_to_back(330);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (MBOX_DEPTH + 8) @(posedge clk);

    $display("Covered %0d transactions: %0d sends stored, %0d refused on a full mailbox.",
             n_items, n_stored, n_refused);
    $display("Receives: %0d matched, %0d found nothing; peak occupancy %0d of %0d.",
             n_found, n_missed, peak_held, MBOX_DEPTH);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/smb_pkg.sv
hw/rtl/smb_store.sv
hw/rtl/smb_ctrl.sv
hw/rtl/selective_receive_mailbox.sv
bench/selective_receive_mailbox_tb.sv
